// ----- src/quantized_grid_table_assert.svh -----
// Assertion helpers shared by the grid table RTL.
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef QUANTIZED_GRID_TABLE_ASSERT_SVH
`define QUANTIZED_GRID_TABLE_ASSERT_SVH

// Same-cycle implication: ante |-> cons.
`define QGT_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quantized_grid_table: assertion failed");

// Next-cycle implication: ante |=> cons.
`define QGT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quantized_grid_table: assertion failed");

`endif

// ----- src/qgt_pkg.sv -----
// ----------------------------------------------------------------------------
// qgt_pkg
// Shared constants, codes, types and helpers of the quantized grid table.
// ----------------------------------------------------------------------------
package qgt_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_VALUE_BITS  = 32;

  // Fixed field widths
  localparam int COORD_FIELDS = 4;
  localparam int STEP_W       = 2;
  localparam int COORD_W      = 18;
  localparam int LIN_W        = 12;
  localparam int WORD_W       = 32;
  localparam int SIZE_W       = 9;
  localparam int DIMS_W       = 3;
  localparam int MAX_DIMS     = 4;
  localparam int DIM_LIMIT    = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;
  localparam int SIZE_LIMIT   = 256;
  localparam logic [15:0] Q_ONE_MINUS = 16'hFFFF;

  // Queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;
  localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

  // Request codes
  localparam logic       REQ_READ    = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;
  localparam logic [1:0] MODE_INDEX  = 2'd0;
  localparam logic [1:0] MODE_NORM   = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;

  typedef struct packed {
    logic [DIMS_W-1:0]                  num_dims;
    logic [COORD_FIELDS-1:0][SIZE_W-1:0] dim_size;
  } qgt_cfg_t;

  typedef struct packed {
    logic write;
    logic bad;
  } qgt_ctrl_t;

  // Size register as used: zero acts as one, large values saturate
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(SIZE_LIMIT)) begin
      r = SIZE_W'(SIZE_LIMIT);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ----- src/qgt_if.sv -----
// ----------------------------------------------------------------------------
// qgt_if
// Request and response channels of the quantized grid table.
// ----------------------------------------------------------------------------
interface qgt_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [1:0]                         addr_mode;
  logic signed [qgt_pkg::COORD_W-1:0] coord_0;
  logic signed [qgt_pkg::COORD_W-1:0] coord_1;
  logic signed [qgt_pkg::COORD_W-1:0] coord_2;
  logic signed [qgt_pkg::COORD_W-1:0] coord_3;
  logic [qgt_pkg::LIN_W-1:0]          linear_addr;
  logic [qgt_pkg::WORD_W-1:0]         write_value;

  modport source (output valid, req_type, addr_mode, coord_0, coord_1, coord_2, coord_3,
                  linear_addr, write_value, input ready);
  modport sink (input valid, req_type, addr_mode, coord_0, coord_1, coord_2, coord_3,
                linear_addr, write_value, output ready);
endinterface

interface qgt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [qgt_pkg::WORD_W-1:0] read_value;
  logic [qgt_pkg::LIN_W-1:0]  cell_addr;
  logic                       out_of_range;

  modport source (output valid, read_value, cell_addr, out_of_range, input ready);
  modport sink (input valid, read_value, cell_addr, out_of_range, output ready);
endinterface

// ----- src/qgt_queue.sv -----
// ----------------------------------------------------------------------------
// qgt_queue
// Short FIFO that decouples address calculation from the table access.
// ----------------------------------------------------------------------------
`include "quantized_grid_table_assert.svh"

module qgt_queue #(
  parameter int DATA_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  qgt_pkg::qgt_ctrl_t push_ctrl,
  input  logic [DATA_W-1:0]  push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output qgt_pkg::qgt_ctrl_t pop_ctrl,
  output logic [DATA_W-1:0]  pop_data
);

  localparam int PTR_W = $clog2(qgt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(qgt_pkg::QUEUE_DEPTH + 1);

  qgt_pkg::qgt_ctrl_t ctrl_q [qgt_pkg::QUEUE_DEPTH];
  logic [DATA_W-1:0]  data_q [qgt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count != CNT_W'(qgt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_ctrl   = ctrl_q[rd_ptr];
  assign pop_data   = data_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      ctrl_q[wr_ptr] <= push_ctrl;
      data_q[wr_ptr] <= push_data;
    end
  end

  `QGT_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(qgt_pkg::QUEUE_DEPTH))
  `QGT_ASSERT_NEXT(a_push_fills, clk, rst, push_fire && !pop_fire, count != '0)

endmodule

// ----- src/qgt_front.sv -----
// ----------------------------------------------------------------------------
// qgt_front
// Accepts requests and folds coordinates into a row-major address and bound.
// ----------------------------------------------------------------------------
`include "quantized_grid_table_assert.svh"

module qgt_front #(
  parameter int TABLE_DEPTH = qgt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = qgt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           hold,
  input  qgt_pkg::qgt_cfg_t              cfg,
  qgt_req_if.sink                        req,
  output logic                           push_valid,
  input  logic                           push_ready,
  output qgt_pkg::qgt_ctrl_t             push_ctrl,
  output logic [$clog2(TABLE_DEPTH)-1:0] push_addr,
  output logic [VALUE_BITS-1:0]          push_wdata
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int SAT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MAC_W  = SAT_W + qgt_pkg::SIZE_W + 1;
  localparam int BND_W  = SAT_W + qgt_pkg::SIZE_W;
  localparam int CMP_W  = (SAT_W > qgt_pkg::LIN_W) ? SAT_W : qgt_pkg::LIN_W;
  localparam int NRM_W  = 16 + qgt_pkg::SIZE_W;
  localparam logic [MAC_W-1:0] DEPTH_MAC = MAC_W'(TABLE_DEPTH);
  localparam logic [BND_W-1:0] DEPTH_BND = BND_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                                           state;
  logic [qgt_pkg::STEP_W-1:0]                        step;
  logic                                              req_w;
  logic [1:0]                                        mode;
  logic [qgt_pkg::COORD_FIELDS-1:0][qgt_pkg::COORD_W-1:0] coord;
  logic [qgt_pkg::LIN_W-1:0]                         lin;
  logic [VALUE_BITS-1:0]                             wdata;
  logic [SAT_W-1:0]                                  addr_acc;
  logic [SAT_W-1:0]                                  bound_acc;
  logic                                              bad;

  logic                          accept;
  logic [qgt_pkg::DIMS_W-1:0]    n_eff;
  logic                          last;
  logic [qgt_pkg::SIZE_W-1:0]    sz;
  logic [qgt_pkg::COORD_W-1:0]   cur;
  logic [15:0]                   cq;
  logic [NRM_W-1:0]              norm_prod;
  logic                          int_bad;
  logic [qgt_pkg::SIZE_W-1:0]    ix;
  logic [SAT_W-1:0]              base;
  logic [MAC_W-1:0]              mac;
  logic [BND_W-1:0]              bprod;
  logic [SAT_W-1:0]              addr_step;
  logic [SAT_W-1:0]              bound_step;
  logic [CMP_W-1:0]              sel;
  logic                          final_bad;

  assign req.ready = (state == F_IDLE) && !hold;
  assign accept    = req.valid && req.ready;

  assign n_eff = (cfg.num_dims == '0) ? qgt_pkg::DIMS_W'(1) :
                 (cfg.num_dims > qgt_pkg::DIMS_W'(qgt_pkg::DIM_LIMIT)) ?
                 qgt_pkg::DIMS_W'(qgt_pkg::DIM_LIMIT) : cfg.num_dims;
  assign last  = (qgt_pkg::DIMS_W'(step) == n_eff - qgt_pkg::DIMS_W'(1));

  // One dimension per step
  assign sz  = qgt_pkg::eff_size(cfg.dim_size[step]);
  assign cur = coord[step];

  // Clamp the coordinate to [0, 1 - 2^-16], scale and floor
  assign cq        = cur[qgt_pkg::COORD_W-1] ? 16'h0 :
                     cur[16] ? qgt_pkg::Q_ONE_MINUS : cur[15:0];
  assign norm_prod = NRM_W'(cq) * NRM_W'(sz);
  assign int_bad   = cur[qgt_pkg::COORD_W-1] || (cur[16:0] >= 17'(sz));

  always_comb begin
    if (mode == qgt_pkg::MODE_INDEX) begin
      ix = int_bad ? '0 : cur[qgt_pkg::SIZE_W-1:0];
    end else begin
      ix = norm_prod[NRM_W-1:16];
    end
  end

  assign base       = (step == '0) ? '0 : addr_acc;
  assign mac        = MAC_W'(base) * MAC_W'(sz) + MAC_W'(ix);
  assign addr_step  = (mac > DEPTH_MAC) ? SAT_W'(TABLE_DEPTH) : SAT_W'(mac);
  assign bprod      = BND_W'(bound_acc) * BND_W'(sz);
  assign bound_step = (bprod > DEPTH_BND) ? SAT_W'(TABLE_DEPTH) : SAT_W'(bprod);

  // Final address and range check
  assign sel       = (mode == qgt_pkg::MODE_LINEAR) ? CMP_W'(lin) : CMP_W'(addr_acc);
  assign final_bad = bad || (sel >= CMP_W'(bound_acc));

  assign push_valid      = (state == F_PUSH);
  assign push_ctrl.write = (req_w == qgt_pkg::REQ_WRITE);
  assign push_ctrl.bad   = final_bad;
  assign push_addr       = final_bad ? '0 : ADDR_W'(sel);
  assign push_wdata      = wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_CALC;
            step  <= '0;
          end
        end
        F_CALC: begin
          if (last) begin
            state <= F_PUSH;
          end else begin
            step <= step + qgt_pkg::STEP_W'(1);
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_w     <= req.req_type;
      mode      <= req.addr_mode;
      coord[0]  <= req.coord_0;
      coord[1]  <= req.coord_1;
      coord[2]  <= req.coord_2;
      coord[3]  <= req.coord_3;
      lin       <= req.linear_addr;
      wdata     <= VALUE_BITS'(req.write_value);
      bound_acc <= SAT_W'(1);
      addr_acc  <= '0;
      bad       <= !(req.addr_mode inside {qgt_pkg::MODE_INDEX, qgt_pkg::MODE_NORM,
                                           qgt_pkg::MODE_LINEAR});
    end else if (state == F_CALC) begin
      addr_acc  <= addr_step;
      bound_acc <= bound_step;
      if (mode == qgt_pkg::MODE_INDEX && int_bad) begin
        bad <= 1'b1;
      end
    end
  end

  `QGT_ASSERT(a_step_in_range, clk, rst, state == F_CALC, qgt_pkg::DIMS_W'(step) < n_eff)

endmodule

// ----- src/qgt_back.sv -----
// ----------------------------------------------------------------------------
// qgt_back
// Table memory with clearing pass, access stage and response register.
// ----------------------------------------------------------------------------
`include "quantized_grid_table_assert.svh"

module qgt_back #(
  parameter int TABLE_DEPTH = qgt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = qgt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           clearing,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  qgt_pkg::qgt_ctrl_t             pop_ctrl,
  input  logic [$clog2(TABLE_DEPTH)-1:0] pop_addr,
  input  logic [VALUE_BITS-1:0]          pop_wdata,
  qgt_rsp_if.source                      rsp
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0]     clr_idx;
  logic                  acc_valid;
  qgt_pkg::qgt_ctrl_t    acc_ctrl;
  logic [ADDR_W-1:0]     acc_addr;
  logic [VALUE_BITS-1:0] acc_wdata;
  logic [VALUE_BITS-1:0] rd_data;

  logic                  pop;
  logic                  we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [VALUE_BITS-1:0] wd;

  assign pop_ready = !clearing && (!acc_valid || rsp.ready);
  assign pop       = pop_valid && pop_ready;

  assign we       = clearing || (pop && pop_ctrl.write && !pop_ctrl.bad);
  assign mem_addr = clearing ? clr_idx : pop_addr;
  assign wd       = clearing ? '0 : pop_wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[mem_addr] <= wd;
    end
    if (pop) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      acc_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + ADDR_W'(1);
        if (clr_idx == ADDR_W'(TABLE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        acc_valid <= 1'b1;
      end else if (rsp.ready) begin
        acc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_ctrl  <= pop_ctrl;
      acc_addr  <= pop_addr;
      acc_wdata <= pop_wdata;
    end
  end

  // A write reports the word just stored; a suppressed access reports zeros
  assign rsp.valid        = acc_valid;
  assign rsp.out_of_range = acc_ctrl.bad;
  assign rsp.cell_addr    = acc_ctrl.bad ? '0 : qgt_pkg::LIN_W'(acc_addr);
  assign rsp.read_value   = acc_ctrl.bad ? '0 :
                            acc_ctrl.write ? qgt_pkg::WORD_W'(acc_wdata) :
                            qgt_pkg::WORD_W'(rd_data);

  `QGT_ASSERT(a_no_pop_clear, clk, rst, clearing, !pop)
  `QGT_ASSERT(a_no_rsp_clear, clk, rst, clearing, !acc_valid)

endmodule

// ----- src/quantized_grid_table.sv -----
// The front takes a new request only once it has pushed the last one to the queue;
// its address loop folds one dimension per cycle through a shared multiply-add,
// over the n dimensions in use (1..4).
// Reset: synchronous; after reset the table is cleared by a pass over all TABLE_DEPTH
// entries (4096 by default) during which no request is accepted.
// Config registers reset to one dimension of size one.
// ----------------------------------------------------------------------------
// quantized_grid_table
// Multidimensional value table: row-major, normalized or linear addressing.
// ----------------------------------------------------------------------------
module quantized_grid_table #(
  parameter int TABLE_DEPTH = qgt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = qgt_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  qgt_req_if.sink                        req,
  qgt_rsp_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qgt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qgt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qgt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int DATA_W = ADDR_W + VALUE_BITS;

  // Configuration registers
  logic [qgt_pkg::DIMS_W-1:0]                         num_dims;
  logic [qgt_pkg::COORD_FIELDS-1:0][qgt_pkg::SIZE_W-1:0] dim_size;
  qgt_pkg::qgt_cfg_t                                  cfg;
  logic                                               cfg_we;
  logic [qgt_pkg::REG_IDX_W-1:0]                      reg_idx;

  // Front to queue
  logic                  f_valid;
  logic                  f_ready;
  qgt_pkg::qgt_ctrl_t    f_ctrl;
  logic [ADDR_W-1:0]     f_addr;
  logic [VALUE_BITS-1:0] f_wdata;
  logic [DATA_W-1:0]     f_data;

  // Queue to back
  logic                  b_valid;
  logic                  b_ready;
  qgt_pkg::qgt_ctrl_t    b_ctrl;
  logic [ADDR_W-1:0]     b_addr;
  logic [VALUE_BITS-1:0] b_wdata;
  logic [DATA_W-1:0]     b_data;

  logic                  clearing;

  // --------------------------------------------------------------------------
  // APB register file: write on the access phase, no wait states
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[qgt_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= qgt_pkg::DIMS_W'(1);
      for (int i = 0; i < qgt_pkg::COORD_FIELDS; i++) begin
        dim_size[i] <= qgt_pkg::SIZE_W'(1);
      end
    end else if (cfg_we) begin
      case (reg_idx)
        qgt_pkg::REG_NUM_DIMS:   num_dims    <= pwdata[qgt_pkg::DIMS_W-1:0];
        qgt_pkg::REG_DIM_SIZE_0: dim_size[0] <= pwdata[qgt_pkg::SIZE_W-1:0];
        qgt_pkg::REG_DIM_SIZE_1: dim_size[1] <= pwdata[qgt_pkg::SIZE_W-1:0];
        qgt_pkg::REG_DIM_SIZE_2: dim_size[2] <= pwdata[qgt_pkg::SIZE_W-1:0];
        qgt_pkg::REG_DIM_SIZE_3: dim_size[3] <= pwdata[qgt_pkg::SIZE_W-1:0];
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qgt_pkg::REG_NUM_DIMS:   prdata = qgt_pkg::CFG_DATA_W'(num_dims);
      qgt_pkg::REG_DIM_SIZE_0: prdata = qgt_pkg::CFG_DATA_W'(dim_size[0]);
      qgt_pkg::REG_DIM_SIZE_1: prdata = qgt_pkg::CFG_DATA_W'(dim_size[1]);
      qgt_pkg::REG_DIM_SIZE_2: prdata = qgt_pkg::CFG_DATA_W'(dim_size[2]);
      qgt_pkg::REG_DIM_SIZE_3: prdata = qgt_pkg::CFG_DATA_W'(dim_size[3]);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.num_dims = num_dims;
  assign cfg.dim_size = dim_size;

  // --------------------------------------------------------------------------
  // Front: accept a request, classify it, fold the coordinates into an
  // address and the table bound one dimension per cycle. Hold off new
  // requests while the back is still clearing the table.
  // --------------------------------------------------------------------------
  qgt_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .cfg        (cfg),
    .req        (req),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ctrl  (f_ctrl),
    .push_addr  (f_addr),
    .push_wdata (f_wdata)
  );

  // --------------------------------------------------------------------------
  // Queue: carry resolved accesses so the front can start on the next
  // request while the back waits on a stalled response.
  // --------------------------------------------------------------------------
  assign f_data            = {f_addr, f_wdata};
  assign {b_addr, b_wdata} = b_data;

  qgt_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_ctrl  (f_ctrl),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_ctrl   (b_ctrl),
    .pop_data   (b_data)
  );

  // --------------------------------------------------------------------------
  // Back: single-port table memory, one access per cycle while responses are taken,
  // registered read, response held until taken. Suppressed accesses skip the write.
  // --------------------------------------------------------------------------
  qgt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_ctrl  (b_ctrl),
    .pop_addr  (b_addr),
    .pop_wdata (b_wdata),
    .rsp       (rsp)
  );

endmodule
